// ----- src/lineage_survival_table_macros.svh -----
// Assertion helpers for the lineage survival table.
`ifndef LINEAGE_SURVIVAL_TABLE_MACROS_SVH
`define LINEAGE_SURVIVAL_TABLE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define LST_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lineage survival table check failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define LST_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lineage survival table check failed");

`endif

// ----- src/lst_pkg.sv -----
package lst_pkg;

  localparam int CNT_W     = 7;
  localparam int KEY_W     = 16;
  localparam int FIT_W     = 32;
  localparam int TOL_W     = 31;
  localparam int STAG_W    = 16;
  localparam int SURV_W    = 17;
  localparam int SUM_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 96;

  localparam logic [1:0] REQ_RECORD  = 2'd0;
  localparam logic [1:0] REQ_EXTINCT = 2'd1;
  localparam logic [1:0] REQ_SURVIVE = 2'd2;
  localparam logic [1:0] REQ_NEAR    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 2'd1;

  localparam logic [15:0] WINDOW_DEF = 16'd10;
  localparam logic [15:0] RATE_DEF   = 16'd6554;
  localparam logic [15:0] WIN_MUL    = 16'd45875;
  localparam logic [15:0] DECAY_MUL  = 16'd58982;
  localparam logic [17:0] WIN_ADD    = 18'd19661;
  localparam logic [16:0] ONE_Q16    = 17'h10000;

  typedef struct packed {
    logic [FIT_W-1:0]  best;
    logic [STAG_W-1:0] stag;
    logic [SURV_W-1:0] surv;
    logic              ext;
  } entry_t;

  typedef struct packed {
    logic [SUM_W-1:0]  imp_total;
    logic [SUM_W-1:0]  ext_total;
    logic [CNT_W-1:0]  count;
    logic [SURV_W-1:0] survival;
    logic              found;
    logic [CNT_W-1:0]  entry_id;
  } out_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_REC_RD,
    CMD_REC_MUL,
    CMD_REC_WR,
    CMD_EMIT_ZERO,
    CMD_SCAN_RD,
    CMD_EX_CHK,
    CMD_EX_EMIT,
    CMD_SV_RD,
    CMD_SV_EMIT,
    CMD_NM_CHK,
    CMD_NM_END
  } cmd_t;

  typedef struct packed {
    logic rec_full;
    logic scan_end;
    logic nm_stop;
    logic out_free;
  } status_t;

endpackage

// ----- src/lineage_survival_table.sv -----
// Lineage survival table, up to MAX_LINEAGES entries held in one single-port
// memory. One request is worked at a time. A record reads its entry, computes
// the new survival, then writes the entry back and emits the result (a full
// table emits a zero result instead); a survival query reads, then emits. An
// extinction pass or a near-miss query walks the entries one by one, a memory
// read and then a check per entry; a near-miss query stops early once max_ids
// matches are found. Result-side stalls can hold a request back. The table
// needs no clearing after reset; a new entry is written in full when appended.
module lineage_survival_table #(
  parameter int MAX_LINEAGES = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // lineage_key, fitness, winner_loss, tolerance, max_ids, 2 pad bits
  input  logic [lst_pkg::IN_DATA_W-1:0]         in_tdata,
  // req_type
  input  logic [1:0]                            in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // entry_id, found, survival, count, extinctions_total, improvements_total
  output logic [lst_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                  out_tlast,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lst_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [15:0]                           cfg_data
);
  import lst_pkg::*;

  cmd_t    cmd;
  status_t st;

  lst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  lst_dp #(
    .MAX_LINEAGES (MAX_LINEAGES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .st         (st),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- src/lst_ctrl.sv -----
module lst_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic [1:0]       in_tuser,
  output logic             in_tready,
  input  lst_pkg::status_t st,
  output lst_pkg::cmd_t    cmd
);
  import lst_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_REC_RD, S_REC_MUL, S_REC_WR, S_REC_FULL,
    S_EX_RD, S_EX_CHK, S_EX_EMIT, S_SV_RD, S_SV_EMIT,
    S_NM_RD, S_NM_CHK, S_NM_END
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd = CMD_LOAD;
          unique case (in_tuser)
            REQ_RECORD:  state_nxt = S_REC_RD;
            REQ_EXTINCT: state_nxt = S_EX_RD;
            REQ_SURVIVE: state_nxt = S_SV_RD;
            default:     state_nxt = S_NM_RD;
          endcase
        end
      end
      S_REC_RD: begin
        if (st.rec_full) begin
          state_nxt = S_REC_FULL;
        end else begin
          cmd       = CMD_REC_RD;
          state_nxt = S_REC_MUL;
        end
      end
      S_REC_MUL: begin
        cmd       = CMD_REC_MUL;
        state_nxt = S_REC_WR;
      end
      S_REC_WR: begin
        if (st.out_free) begin
          cmd       = CMD_REC_WR;
          state_nxt = S_IDLE;
        end
      end
      S_REC_FULL: begin
        if (st.out_free) begin
          cmd       = CMD_EMIT_ZERO;
          state_nxt = S_IDLE;
        end
      end
      S_EX_RD: begin
        if (st.scan_end) begin
          state_nxt = S_EX_EMIT;
        end else begin
          cmd       = CMD_SCAN_RD;
          state_nxt = S_EX_CHK;
        end
      end
      S_EX_CHK: begin
        cmd       = CMD_EX_CHK;
        state_nxt = S_EX_RD;
      end
      S_EX_EMIT: begin
        if (st.out_free) begin
          cmd       = CMD_EX_EMIT;
          state_nxt = S_IDLE;
        end
      end
      S_SV_RD: begin
        cmd       = CMD_SV_RD;
        state_nxt = S_SV_EMIT;
      end
      S_SV_EMIT: begin
        if (st.out_free) begin
          cmd       = CMD_SV_EMIT;
          state_nxt = S_IDLE;
        end
      end
      S_NM_RD: begin
        if (st.scan_end || st.nm_stop) begin
          state_nxt = S_NM_END;
        end else begin
          cmd       = CMD_SCAN_RD;
          state_nxt = S_NM_CHK;
        end
      end
      S_NM_CHK: begin
        if (st.out_free) begin
          cmd       = CMD_NM_CHK;
          state_nxt = S_NM_RD;
        end
      end
      S_NM_END: begin
        if (st.out_free) begin
          cmd       = CMD_NM_END;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- src/lst_dp.sv -----
module lst_dp #(
  parameter int MAX_LINEAGES = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [lst_pkg::IN_DATA_W-1:0]      in_tdata,
  input  lst_pkg::cmd_t                      cmd,
  output lst_pkg::status_t                   st,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [15:0]                        cfg_data,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lst_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tlast
);
  import lst_pkg::*;

  localparam int IW = (MAX_LINEAGES > 1) ? $clog2(MAX_LINEAGES) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LINEAGES);

  entry_t mem [MAX_LINEAGES];
  entry_t rd_r;

  logic [KEY_W-1:0]  key_r;
  logic [FIT_W-1:0]  fit_r, winner_r;
  logic [TOL_W-1:0]  tol_r;
  logic [CNT_W-1:0]  cap_r;
  logic [15:0]       window_r, rate_r;
  logic [CNT_W-1:0]  lcount_r;
  logic [SUM_W-1:0]  ext_sum_r, imp_sum_r;
  logic [IW-1:0]     idx_r;
  logic              new_r, hit_r, win_r;
  entry_t            ent_r;
  logic [32:0]       prod_r;
  logic [CNT_W-1:0]  i_r, k_r, cnt_r;
  logic              pend_v_r;
  logic [CNT_W-1:0]  pend_id_r;
  logic [SURV_W-1:0] pend_s_r;
  logic              out_valid_r, out_last_r;
  out_t              out_r;

  logic              key_hit;
  logic [IW-1:0]     key_idx, rd_addr;
  entry_t            cur, wr_data;
  logic              we, re;
  logic              rec_win;
  logic [32:0]       rec_prod, rnd;
  logic [17:0]       win_sum;
  logic [SURV_W-1:0] s_new;
  logic [STAG_W-1:0] stag_inc;
  logic [SUM_W-1:0]  imp_nxt;
  logic [15:0]       win_eff, rate_eff;
  logic [31:0]       press;
  logic [SURV_W-1:0] room;
  logic              ex_hit, nm_hit;
  logic [32:0]       diff;
  logic [CNT_W-1:0]  cap_eff;
  logic              emit;
  out_t              emit_data;
  logic              emit_last;

  assign key_hit  = (key_r != '0) && (key_r <= KEY_W'(lcount_r));
  assign key_idx  = IW'(key_r - KEY_W'(1));
  assign cur      = new_r ? '0 : rd_r;
  assign rec_win  = ($signed(fit_r) < $signed(cur.best)) || (cur.best == '0);
  assign rec_prod = 33'(cur.surv) * 33'(rec_win ? WIN_MUL : DECAY_MUL);
  assign rnd      = prod_r + 33'd32768;
  assign win_sum  = {1'b0, rnd[32:16]} + WIN_ADD;
  assign s_new    = win_r ? ((win_sum > 18'(ONE_Q16)) ? ONE_Q16 : win_sum[16:0])
                          : rnd[32:16];
  assign stag_inc = (ent_r.stag == '1) ? ent_r.stag : ent_r.stag + 1'b1;
  assign imp_nxt  = (win_r && imp_sum_r != '1) ? imp_sum_r + 1'b1 : imp_sum_r;

  assign win_eff  = (window_r == '0) ? WINDOW_DEF : window_r;
  assign rate_eff = (rate_r == '0) ? RATE_DEF : rate_r;
  assign press    = rd_r.stag * rate_eff;
  assign room     = ONE_Q16 - ((rd_r.surv > ONE_Q16) ? ONE_Q16 : rd_r.surv);
  assign ex_hit   = !rd_r.ext && (rd_r.stag >= win_eff) && (press > 32'(room));

  assign diff     = {rd_r.best[31], rd_r.best} - {winner_r[31], winner_r};
  assign nm_hit   = ($signed(rd_r.best) > $signed(winner_r)) &&
                    (diff <= 33'(tol_r));
  assign cap_eff  = (cap_r > MAX_CNT) ? MAX_CNT : cap_r;

  assign st.rec_full = !key_hit && (lcount_r >= MAX_CNT);
  assign st.scan_end = (i_r >= lcount_r);
  assign st.nm_stop  = (k_r >= cap_eff);
  assign st.out_free = !out_valid_r || out_tready;

  // read data is held until the next read, so a stalled emit sees it unchanged
  assign re = (cmd == CMD_REC_RD) || (cmd == CMD_SV_RD) || (cmd == CMD_SCAN_RD);

  always_comb begin
    rd_addr = i_r[IW-1:0];
    case (cmd)
      CMD_REC_RD: rd_addr = key_hit ? key_idx : lcount_r[IW-1:0];
      CMD_SV_RD:  rd_addr = key_idx;
      default:    rd_addr = i_r[IW-1:0];
    endcase
  end

  always_comb begin
    we      = 1'b0;
    wr_data = rd_r;
    if (cmd == CMD_REC_WR) begin
      we           = 1'b1;
      wr_data.best = win_r ? fit_r : ent_r.best;
      wr_data.stag = win_r ? '0 : stag_inc;
      wr_data.surv = s_new;
      wr_data.ext  = ent_r.ext;
    end else if (cmd == CMD_EX_CHK && ex_hit) begin
      we           = 1'b1;
      wr_data.ext  = 1'b1;
      wr_data.surv = '0;
    end
  end

  always_comb begin
    emit      = 1'b0;
    emit_last = 1'b1;
    emit_data = '0;
    emit_data.ext_total = ext_sum_r;
    emit_data.imp_total = imp_sum_r;
    case (cmd)
      CMD_REC_WR: begin
        emit                = 1'b1;
        emit_data.entry_id  = CNT_W'(idx_r) + 1'b1;
        emit_data.found     = 1'b1;
        emit_data.survival  = s_new;
        emit_data.imp_total = imp_nxt;
      end
      CMD_EMIT_ZERO: emit = 1'b1;
      CMD_EX_EMIT: begin
        emit            = 1'b1;
        emit_data.count = cnt_r;
      end
      CMD_SV_EMIT: begin
        emit = 1'b1;
        if (hit_r) begin
          emit_data.entry_id = key_r[CNT_W-1:0];
          emit_data.found    = 1'b1;
          emit_data.survival = rd_r.surv;
        end
      end
      CMD_NM_CHK, CMD_NM_END: begin
        emit      = (cmd == CMD_NM_END) || (nm_hit && pend_v_r);
        emit_last = (cmd == CMD_NM_END);
        if (pend_v_r) begin
          emit_data.entry_id = pend_id_r;
          emit_data.found    = 1'b1;
          emit_data.survival = pend_s_r;
          emit_data.count    = k_r;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[idx_r & {IW{cmd == CMD_REC_WR}} | i_r[IW-1:0] & {IW{cmd != CMD_REC_WR}}] <= wr_data;
    end
    if (re) begin
      rd_r <= mem[rd_addr];
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= WINDOW_DEF;
      rate_r      <= RATE_DEF;
      lcount_r    <= '0;
      ext_sum_r   <= '0;
      imp_sum_r   <= '0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      i_r         <= '0;
      k_r         <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_WINDOW: window_r <= cfg_data;
          CFG_RATE:   rate_r   <= cfg_data;
          default:    ;
        endcase
      end
      if (emit) begin
        out_valid_r <= 1'b1;
        out_r       <= emit_data;
        out_last_r  <= emit_last;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd)
        CMD_LOAD: begin
          key_r    <= in_tdata[15:0];
          fit_r    <= in_tdata[47:16];
          winner_r <= in_tdata[79:48];
          tol_r    <= in_tdata[110:80];
          cap_r    <= in_tdata[117:111];
          i_r      <= '0;
          k_r      <= '0;
          cnt_r    <= '0;
          pend_v_r <= 1'b0;
        end
        CMD_REC_RD: begin
          idx_r <= key_hit ? key_idx : lcount_r[IW-1:0];
          new_r <= !key_hit;
        end
        CMD_REC_MUL: begin
          ent_r  <= cur;
          win_r  <= rec_win;
          prod_r <= rec_prod;
        end
        CMD_REC_WR: begin
          imp_sum_r <= imp_nxt;
          if (new_r) lcount_r <= lcount_r + 1'b1;
        end
        CMD_EX_CHK: begin
          i_r <= i_r + 1'b1;
          if (ex_hit) begin
            cnt_r <= cnt_r + 1'b1;
            if (ext_sum_r != '1) ext_sum_r <= ext_sum_r + 1'b1;
          end
        end
        CMD_SV_RD: hit_r <= key_hit;
        CMD_NM_CHK: begin
          i_r <= i_r + 1'b1;
          if (nm_hit) begin
            k_r       <= k_r + 1'b1;
            pend_v_r  <= 1'b1;
            pend_id_r <= i_r + 1'b1;
            pend_s_r  <= rd_r.surv;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- src/lst_checker.sv -----
`include "lineage_survival_table_macros.svh"

module lst_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [lst_pkg::OUT_DATA_W-1:0]    out_tdata
);

  // a stalled result stays offered
  `LST_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

  // no entry means no survival
  `LST_ASSERT_IMP(a_miss_zero, clk, rst_n, out_tvalid && !out_tdata[7], out_tdata[24:8] == 17'd0)

  // survival stays within Q1.16 one
  `LST_ASSERT_IMP(a_surv_range, clk, rst_n, out_tvalid, out_tdata[24:8] <= 17'h10000)

  // id zero is never reported as found
  `LST_ASSERT_IMP(a_id_found, clk, rst_n, out_tvalid && out_tdata[6:0] == 7'd0, !out_tdata[7])

endmodule

bind lineage_survival_table lst_checker u_lst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- dv/lineage_survival_table_tb.sv -----
module lineage_survival_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lst_pkg::*;

  localparam int NLIN = 64;
  localparam longint LIMIT = 2000000;

  typedef struct {
    logic [6:0]  entry_id;
    logic        found;
    logic [16:0] survival;
    logic [6:0]  count;
    logic        last;
    logic [31:0] ext_total;
    logic [31:0] imp_total;
  } result_t;

  class lineage_scoreboard;
    logic [15:0] window, rate;
    int unsigned n_lin;
    logic signed [31:0] best[NLIN];
    logic [15:0] stag[NLIN];
    logic [16:0] surv[NLIN];
    logic        ext[NLIN];
    logic [31:0] ext_sum, imp_sum;
    result_t pending[$];
    int errors;
    int n_checked;

    function new();
      window = WINDOW_DEF;
      rate = RATE_DEF;
      n_lin = 0;
      ext_sum = 0;
      imp_sum = 0;
      errors = 0;
      n_checked = 0;
    endfunction

    function void push(logic [6:0] id, logic f, logic [16:0] s, logic [6:0] c, logic l);
      result_t r;
      r.entry_id = id; r.found = f; r.survival = s; r.count = c; r.last = l;
      r.ext_total = ext_sum; r.imp_total = imp_sum;
      pending.push_back(r);
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] v);
      if (idx == CFG_WINDOW) window = v;
      else if (idx == CFG_RATE) rate = v;
    endfunction

    function void note_request(logic [1:0] req, logic [15:0] key, logic signed [31:0] fit,
                               logic signed [31:0] winner, logic [30:0] tol,
                               logic [6:0] max_ids);
      int unsigned idx, k, cap, cnt, w, r;
      longint unsigned s, press, room;
      longint dlt;
      case (req)
        REQ_RECORD: begin
          if (key != 0 && key <= n_lin) idx = key - 1;
          else if (n_lin >= NLIN) begin
            push(0, 0, 0, 0, 1);
            return;
          end else begin
            idx = n_lin++;
            best[idx] = 0; stag[idx] = 0; surv[idx] = 0; ext[idx] = 0;
          end
          s = surv[idx];
          if (fit < best[idx] || best[idx] == 0) begin
            best[idx] = fit;
            stag[idx] = 0;
            s = ((s * 45875 + 32768) >> 16) + 19661;
            if (s > 65536) s = 65536;
            if (imp_sum != 32'hffffffff) imp_sum++;
          end else begin
            if (stag[idx] != 16'hffff) stag[idx]++;
            s = (s * 58982 + 32768) >> 16;
          end
          surv[idx] = 17'(s);
          push(7'(idx + 1), 1, 17'(s), 0, 1);
        end
        REQ_EXTINCT: begin
          w = window ? window : 10;
          r = rate ? rate : 6554;
          cnt = 0;
          for (int i = 0; i < n_lin; i++) begin
            if (ext[i] || stag[i] < w) continue;
            press = longint'(stag[i]) * r;
            room = 65536 - (surv[i] > 65536 ? 65536 : surv[i]);
            if (press > room) begin
              ext[i] = 1; surv[i] = 0; cnt++;
              if (ext_sum != 32'hffffffff) ext_sum++;
            end
          end
          push(0, 0, 0, 7'(cnt), 1);
        end
        REQ_SURVIVE: begin
          if (key != 0 && key <= n_lin) push(key[6:0], 1, surv[key - 1], 0, 1);
          else push(0, 0, 0, 0, 1);
        end
        default: begin
          cap = max_ids > NLIN ? NLIN : max_ids;
          k = 0;
          for (int i = 0; i < n_lin && k < cap; i++) begin
            dlt = longint'(best[i]) - longint'(winner);
            if (dlt > 0 && dlt <= longint'(tol)) begin
              k++;
              push(7'(i + 1), 1, surv[i], 7'(k), 0);
            end
          end
          if (k == 0) push(0, 0, 0, 0, 1);
          else pending[$].last = 1;
        end
      endcase
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d, logic l);
      result_t e;
      n_checked++;
      if (pending.size() == 0) begin
        $error("unexpected result transaction %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[6:0] !== e.entry_id) begin
        $error("entry_id exp %0d got %0d", e.entry_id, d[6:0]); errors++;
      end
      if (d[7] !== e.found) begin
        $error("found exp %0d got %0d", e.found, d[7]); errors++;
      end
      if (d[24:8] !== e.survival) begin
        $error("survival exp %0d got %0d", e.survival, d[24:8]); errors++;
      end
      if (d[31:25] !== e.count) begin
        $error("count exp %0d got %0d", e.count, d[31:25]); errors++;
      end
      if (l !== e.last) begin
        $error("last exp %0d got %0d", e.last, l); errors++;
      end
      if (d[63:32] !== e.ext_total) begin
        $error("extinctions_total exp %0d got %0d", e.ext_total, d[63:32]); errors++;
      end
      if (d[95:64] !== e.imp_total) begin
        $error("improvements_total exp %0d got %0d", e.imp_total, d[95:64]); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [1:0] in_tuser;
  logic out_tvalid, out_tready, out_tlast;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0] cfg_data;

  lineage_survival_table dut (.*);

  lineage_scoreboard sb;
  longint cycles;
  bit idle_free;
  int hold_off;
  int n_items;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    in_tvalid = 0; in_tdata = '0; in_tuser = REQ_RECORD;
    out_tready = 0; cfg_valid = 0; cfg_index = CFG_WINDOW; cfg_data = '0;
    rst_n = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end
  initial cycles = 0;

  // result side: random stalls plus commanded hold-off
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 0;
    end else
      out_tready <= idle_free ? 1'b1 : ($urandom_range(99) >= 32);
  end
  initial hold_off = 0;

  // valid stays up after a transaction until the next idle cycle or drain
  task automatic send(logic [1:0] req, logic [15:0] key, logic signed [31:0] fit,
                      logic signed [31:0] winner, logic [30:0] tol, logic [6:0] max_ids);
    while (!idle_free && $urandom_range(99) < 32) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= req;
    in_tdata <= {2'b00, max_ids, tol, winner, fit, key};
    do @(posedge clk); while (!in_tready);
    sb.note_request(req, key, fit, winner, tol, max_ids);
    n_items++;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] v);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_key();
    int unsigned n;
    n = sb.n_lin;
    case ($urandom_range(9))
      0: return 0;
      1: return 16'($urandom_range(65535));
      2: return 16'(n + 1);
      default: return n ? 16'($urandom_range(n)) : 16'd0;
    endcase
  endfunction

  function automatic logic [31:0] rand_fit();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h80000000;
      2: return 32'h7fffffff;
      default: return $urandom_range(400) << 12;
    endcase
  endfunction

  task automatic rand_item();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 60) send(REQ_RECORD, rand_key(), rand_fit(), 0, 0, 0);
    else if (p < 72) send(REQ_EXTINCT, 16'($urandom), $urandom, $urandom,
                          31'($urandom), 7'($urandom));
    else if (p < 84) send(REQ_SURVIVE, rand_key(), $urandom, 0, 0, 0);
    else send(REQ_NEAR, 16'($urandom), $urandom, $urandom_range(100) << 12,
              31'($urandom_range(3) == 0 ? $urandom : ($urandom_range(200) << 12)),
              7'($urandom_range(3) == 0 ? $urandom_range(127) : $urandom_range(6)));
  endtask

  initial begin
    sb = new();
    idle_free = 0;
    n_items = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, every request type, special cases
    send(REQ_SURVIVE, 1, 0, 0, 0, 0);
    send(REQ_NEAR, 0, 0, 0, 31'h7fffffff, 64);
    send(REQ_EXTINCT, 0, 0, 0, 0, 0);
    send(REQ_RECORD, 0, 32'sh7fffffff, 0, 0, 0);
    send(REQ_RECORD, 1, 32'sh80000000, 0, 0, 0);
    send(REQ_RECORD, 1, 32'sh80000000, 0, 0, 0);
    send(REQ_RECORD, 16'hffff, 32'sh00010000, 0, 0, 0);
    send(REQ_RECORD, 2, 0, 0, 0, 0);
    send(REQ_RECORD, 2, 5, 0, 0, 0);
    for (int i = 0; i < 12; i++) send(REQ_RECORD, 3, 32'sh7fffffff, 0, 0, 0);
    send(REQ_EXTINCT, 0, 0, 0, 0, 0);
    send(REQ_RECORD, 2, 32'sh7fffffff, 0, 0, 0);
    send(REQ_SURVIVE, 16'hffff, 0, 0, 0, 0);
    send(REQ_NEAR, 0, 0, 32'sh80000000, 31'h7fffffff, 127);
    send(REQ_NEAR, 0, 0, 32'sh80000000, 31'h7fffffff, 0);
    drain();

    write_reg(CFG_WINDOW, 16'd1);
    write_reg(CFG_RATE, 16'hffff);
    for (int i = 0; i < 60; i++) rand_item();
    drain();

    // receiver stall: input must back up while results wait
    hold_off = 400;
    for (int i = 0; i < 20; i++) send(REQ_RECORD, 0, rand_fit(), 0, 0, 0);
    drain();

    write_reg(CFG_WINDOW, 16'hffff);
    write_reg(CFG_RATE, 16'd1);
    idle_free = 1;
    for (int i = 0; i < 60; i++) rand_item();
    idle_free = 0;
    drain();

    write_reg(CFG_WINDOW, 16'd0);
    write_reg(CFG_RATE, 16'd0);
    for (int i = 0; i < 60; i++) rand_item();
    drain();

    write_reg(CFG_WINDOW, 16'd3);
    write_reg(CFG_RATE, 16'd20000);
    for (int i = 0; i < 50; i++) rand_item();
    drain();

    $display("covered %0d requests, %0d results, %0d lineages stored, %0d extinctions",
             n_items, sb.n_checked, sb.n_lin, sb.ext_sum);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
